// ----- hdl/lvn_pkg.sv -----
// Shared types, widths and constants of the L2 vector normaliser.
// Used by every module under hdl; depends on nothing else.
package lvn_pkg;

  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);

  localparam int ELEM_W   = 16;
  localparam int FRAC_W   = 12;
  localparam int SQ_W     = 2 * ELEM_W;
  localparam int SQ_CNT_W = $clog2(ELEM_W + 1);
  localparam int SUM_W    = 41;
  localparam int NORM_W   = 21;
  localparam int RAD_W    = 2 * NORM_W;
  localparam int RT_CNT_W = $clog2(NORM_W + 1);

  // Quotient below 4 * one is worked out bit by bit; 4 * one and above saturates.
  localparam int DIV_STEPS = FRAC_W + 2;
  localparam int DV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int Q_W       = FRAC_W + 1;
  localparam int ONE_Q12   = 1 << FRAC_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [ELEM_W-1:0] element;
    logic                     last;
  } lvn_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     final_res;
    logic                     status;
  } lvn_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT,
    ST_READ,
    ST_DIV
  } lvn_state_t;

endpackage

// ----- hdl/l2_vector_normalizer.sv -----
// L2 vector normaliser. Load words store a Q3.12 element and add its square,
// formed bit-serially, to the running sum; the block is busy while it does so,
// and on the word marked last also while the digit-serial square root produces the norm.
// A drain word returns the next element, and the next word can be taken once
// the element has passed unchanged, gone through the one-bit-a-cycle divider,
// or saturated early, or once an empty status has been returned.
// Each result is shown for one cycle with done; it cannot be held off,
// so take it when it appears. min_sum_sq is sampled when a vector completes.
// Elements live in a single-port memory of MAX_DIM words.
module l2_vector_normalizer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  lvn_pkg::lvn_in_t          item,
  output logic                      done,
  output lvn_pkg::lvn_out_t         result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lvn_pkg::SUM_W-1:0] cfg_data
);
  import lvn_pkg::*;

  lvn_state_t state, state_next;

  logic [ELEM_W-1:0] mem [MAX_DIM];
  logic [ELEM_W-1:0] rdata;

  logic [CNT_W-1:0]  load_count;
  logic [CNT_W-1:0]  drain_index;
  logic [SUM_W-1:0]  sum_squares;
  logic [NORM_W-1:0] norm_value;
  logic [SUM_W-1:0]  min_sum_sq;
  logic              vector_ready;
  logic              do_divide;
  logic              last_q;
  logic              neg_q;

  logic              is_load, is_drain, room, drain_ok, divide_en;
  logic [CNT_W-1:0]  count_eff;
  logic [ELEM_W-1:0] in_mag, rd_mag, qx, qval;
  logic              mem_we, mem_rd, sq_start, rt_start, div_start;
  logic              sq_done, rt_done, div_done;
  logic [SQ_W-1:0]   sq;
  logic [NORM_W-1:0] root;
  logic [Q_W-1:0]    quot;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;

  assign cfg_ready = 1'b1;

  assign is_load   = start && !busy && (item.command == CMD_LOAD);
  assign is_drain  = start && !busy && (item.command == CMD_DRAIN);
  assign count_eff = vector_ready ? '0 : load_count;
  assign room      = count_eff < CNT_W'(MAX_DIM);
  assign drain_ok  = vector_ready && (drain_index < load_count);
  assign divide_en = do_divide && (norm_value != '0);

  assign in_mag = item.element[ELEM_W-1] ? (ELEM_W'(0) - item.element) : item.element;
  assign rd_mag = rdata[ELEM_W-1] ? (ELEM_W'(0) - rdata) : rdata;
  assign qx     = ELEM_W'(quot);
  assign qval   = neg_q ? (ELEM_W'(0) - qx) : qx;

  assign sum_add = {1'b0, sum_squares} + (SUM_W+1)'(sq);
  assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  lvn_square u_square (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .mag  (in_mag),
    .done (sq_done),
    .sq   (sq)
  );

  lvn_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (rt_start),
    .radicand(sum_squares),
    .done    (rt_done),
    .root    (root)
  );

  lvn_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .mag    (rd_mag),
    .divisor(norm_value),
    .done   (div_done),
    .quot   (quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_load) begin
          if (room) begin
            state_next = ST_SQUARE;
          end else if (item.last) begin
            state_next = ST_ROOT_GO;
          end
        end else if (is_drain && drain_ok) begin
          state_next = ST_READ;
        end
      end
      ST_SQUARE: begin
        if (sq_done) begin
          state_next = last_q ? ST_ROOT_GO : ST_IDLE;
        end
      end
      ST_ROOT_GO: state_next = ST_ROOT;
      ST_ROOT: begin
        if (rt_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: state_next = divide_en ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_rd    = 1'b0;
    sq_start  = 1'b0;
    rt_start  = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        mem_we   = is_load && room;
        sq_start = is_load && room;
        mem_rd   = is_drain && drain_ok;
      end
      ST_ROOT_GO: rt_start  = 1'b1;
      ST_READ:    div_start = divide_en;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_eff[DIM_W-1:0]] <= item.element;
    end
    if (mem_rd) begin
      rdata <= mem[drain_index[DIM_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      load_count   <= '0;
      drain_index  <= '0;
      sum_squares  <= '0;
      norm_value   <= '0;
      min_sum_sq   <= '0;
      vector_ready <= 1'b0;
      do_divide    <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        min_sum_sq <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (is_load) begin
            // a load after a finished vector starts afresh
            if (vector_ready) begin
              vector_ready <= 1'b0;
              drain_index  <= '0;
              sum_squares  <= '0;
            end
            load_count <= count_eff + CNT_W'(room);
          end else if (is_drain && !drain_ok) begin
            done <= 1'b1;
          end
        end
        ST_SQUARE: begin
          if (sq_done) begin
            sum_squares <= sum_sat;
          end
        end
        ST_ROOT: begin
          if (rt_done) begin
            norm_value   <= root;
            do_divide    <= sum_squares > min_sum_sq;
            vector_ready <= 1'b1;
            drain_index  <= '0;
          end
        end
        ST_READ: begin
          if (!divide_en) begin
            done        <= 1'b1;
            drain_index <= drain_index + CNT_W'(1);
          end
        end
        ST_DIV: begin
          if (div_done) begin
            done        <= 1'b1;
            drain_index <= drain_index + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && is_load) begin
      last_q <= item.last;
    end
    if (state == ST_READ) begin
      neg_q <= rdata[ELEM_W-1];
    end
    case (state)
      ST_IDLE: begin
        result.value     <= '0;
        result.final_res <= 1'b0;
        result.status    <= STATUS_EMPTY;
      end
      ST_READ: begin
        result.value     <= rdata;
        result.final_res <= (drain_index + CNT_W'(1)) == load_count;
        result.status    <= STATUS_OK;
      end
      ST_DIV: begin
        result.value     <= qval;
        result.final_res <= (drain_index + CNT_W'(1)) == load_count;
        result.status    <= STATUS_OK;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= CNT_W'(MAX_DIM))
    else $error("load count beyond store depth");

  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    vector_ready |-> drain_index <= load_count)
    else $error("drain index passed the loaded length");

  a_ok_needs_vector: assert property (@(posedge clk) disable iff (rst)
    done && result.status == STATUS_OK |-> vector_ready && $past(drain_index) < load_count)
    else $error("element returned without a complete vector");

  a_busy_no_result_on_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQUARE || state == ST_ROOT_GO || state == ST_ROOT |=> !done)
    else $error("result strobe during a load");

endmodule

// ----- hdl/lvn_square.sv -----
// Bit-serial squarer: shift-and-add over one multiplier bit per cycle.
// Depends on lvn_pkg for the element and product widths.
module lvn_square (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lvn_pkg::ELEM_W-1:0] mag,
  output logic                       done,
  output logic [lvn_pkg::SQ_W-1:0]   sq
);
  import lvn_pkg::*;

  logic [ELEM_W:0]   acc;
  logic [ELEM_W-1:0] mq;
  logic [ELEM_W-1:0] mcand;
  logic [SQ_CNT_W-1:0] cnt;
  logic              running;
  logic [ELEM_W:0]   part;

  assign part = acc + (mq[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= SQ_CNT_W'(ELEM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == SQ_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mq    <= mag;
      mcand <= mag;
    end else if (running) begin
      // shift the partial product right, low bit drops into the multiplier register
      acc <= {1'b0, part[ELEM_W:1]};
      mq  <= {part[0], mq[ELEM_W-1:1]};
    end
  end

  assign sq = {acc[ELEM_W-1:0], mq};

endmodule

// ----- hdl/lvn_isqrt.sv -----
// Digit-recurrence floor square root: two radicand bits, one root bit a cycle.
// Depends on lvn_pkg for the sum and norm widths.
module lvn_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lvn_pkg::SUM_W-1:0]  radicand,
  output logic                       done,
  output logic [lvn_pkg::NORM_W-1:0] root
);
  import lvn_pkg::*;

  logic [RAD_W-1:0]    rad;
  logic [NORM_W+1:0]   rem;
  logic [RT_CNT_W-1:0] cnt;
  logic                running;
  logic [NORM_W+3:0]   rs;
  logic [NORM_W+3:0]   trial;
  logic                fits;

  assign rs    = {rem, rad[RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign fits  = rs >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= RT_CNT_W'(NORM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == RT_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (NORM_W+2)'(rs - trial) : rs[NORM_W+1:0];
      root <= {root[NORM_W-2:0], fits};
    end
  end

endmodule

// ----- hdl/lvn_div.sv -----
// Restoring divider for (mag * one) / norm, one quotient bit a cycle,
// with an early exit to the saturated value. Depends on lvn_pkg.
module lvn_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lvn_pkg::ELEM_W-1:0] mag,
  input  logic [lvn_pkg::NORM_W-1:0] divisor,
  output logic                       done,
  output logic [lvn_pkg::Q_W-1:0]    quot
);
  import lvn_pkg::*;

  logic [NORM_W-1:0]    dvs;
  logic [NORM_W-1:0]    rem;
  logic [DIV_STEPS-1:0] low;
  logic [DIV_STEPS-1:0] q;
  logic [DV_CNT_W-1:0]  cnt;
  logic                 running;
  logic                 sat_hit;
  logic [NORM_W:0]      rs;
  logic                 ge;

  // quotient reaches 4 * one exactly when mag >= 4 * divisor
  assign sat_hit = (NORM_W+2)'(mag) >= {divisor, 2'b00};
  assign rs      = {rem, low[DIV_STEPS-1]};
  assign ge      = rs >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= !sat_hit;
        done    <= sat_hit;
        cnt     <= DV_CNT_W'(DIV_STEPS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= NORM_W'(mag[ELEM_W-1:2]);
      low <= DIV_STEPS'({mag[1:0], FRAC_W'(0)});
      q   <= sat_hit ? DIV_STEPS'(ONE_Q12) : '0;
    end else if (running) begin
      rem <= ge ? NORM_W'(rs - {1'b0, dvs}) : rs[NORM_W-1:0];
      low <= {low[DIV_STEPS-2:0], 1'b0};
      q   <= {q[DIV_STEPS-2:0], ge};
    end
  end

  assign quot = (q > DIV_STEPS'(ONE_Q12)) ? Q_W'(ONE_Q12) : q[Q_W-1:0];

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for l2_vector_normalizer: random and directed load/drain words,
// an in-bench predictor of the norm and quotients, and a threshold register sweep.
// Depends on hdl/lvn_pkg.sv and hdl/l2_vector_normalizer.sv with the submodules it instantiates.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lvn_pkg::*;

  localparam logic [63:0] SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
  localparam int          SETTLE      = 64;
  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASE_WORDS = 170;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  lvn_in_t              item      = '0;
  logic                 done;
  lvn_out_t             result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [SUM_W-1:0]     cfg_data  = '0;

  l2_vector_normalizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Bench copy of the normaliser state
  logic [ELEM_W-1:0] elem_mem [MAX_DIM];
  logic [63:0]       sq_sum;
  int unsigned       n_loaded;
  int unsigned       drain_pos;
  logic [NORM_W-1:0] norm;
  bit                vec_done;
  bit                divide_en;
  logic [SUM_W-1:0]  threshold;

  lvn_in_t  pending_words [$];
  lvn_out_t results_due   [$];
  bit       have_word;
  bit       gaps_on;
  int       idle_left;
  int       queued_words;
  int       errors;
  int       words_loaded;
  int       words_drained;
  int       results_checked;
  int       threshold_writes;

  function automatic logic [NORM_W-1:0] floor_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = NORM_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r[NORM_W-1:0];
  endfunction

  // Advance the bench state by one accepted word; a drain leaves one result due.
  function automatic void apply_word(input lvn_in_t w);
    lvn_out_t    r;
    int          e;
    logic [63:0] mag;
    logic [63:0] quo;
    logic [63:0] val;
    if (w.command == CMD_LOAD) begin
      words_loaded++;
      if (vec_done) begin
        vec_done  = 1'b0;
        sq_sum    = '0;
        n_loaded  = 0;
        drain_pos = 0;
      end
      if (n_loaded < MAX_DIM) begin
        e = int'($signed(w.element));
        mag = (e < 0) ? 64'(-e) : 64'(e);
        elem_mem[n_loaded] = w.element;
        n_loaded++;
        if (SUM_LIMIT - sq_sum < mag * mag) sq_sum = SUM_LIMIT;
        else sq_sum = sq_sum + mag * mag;
      end
      if (w.last) begin
        norm      = floor_root(sq_sum);
        divide_en = (sq_sum > {23'b0, threshold});
        vec_done  = 1'b1;
        drain_pos = 0;
      end
    end else begin
      words_drained++;
      if (!vec_done || drain_pos >= n_loaded || drain_pos >= MAX_DIM) begin
        r.value     = '0;
        r.final_res = 1'b0;
        r.status    = STATUS_EMPTY;
      end else begin
        e = int'($signed(elem_mem[drain_pos]));
        val = 64'(e);
        if (divide_en && norm != '0) begin
          mag = (e < 0) ? 64'(-e) : 64'(e);
          quo = (mag * ONE_Q12) / norm;
          if (quo > ONE_Q12) quo = 64'(ONE_Q12);
          val = (e < 0) ? -quo : quo;
        end
        r.value     = val[ELEM_W-1:0];
        r.final_res = (drain_pos + 1 == n_loaded);
        r.status    = STATUS_OK;
        drain_pos++;
      end
      results_due.push_back(r);
    end
  endfunction

  // Driver: hold each word until taken; random idle bursts lower start.
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      have_word  = 1'b0;
      idle_left  = 0;
    end else begin
      if (start && !busy) begin
        apply_word(item);
        have_word = 1'b0;
      end
      if (!have_word && pending_words.size() > 0) begin
        item     <= pending_words.pop_front();
        have_word = 1'b1;
      end
      if (idle_left > 0) idle_left--;
      else if (gaps_on && $urandom_range(0, 11) == 0) idle_left = $urandom_range(1, 7);
      start <= have_word && (idle_left == 0);
    end
  end

  function automatic void report(input string field, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= 200)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
    end
  endfunction

  // Monitor: every done strobe must match the oldest result due.
  always @(posedge clk) begin : monitor
    lvn_out_t want;
    if (!rst && done) begin
      results_checked++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: unexpected result, expected none actual value %0d final %0b status %0b",
                   $time, result.value, result.final_res, result.status);
      end else begin
        want = results_due.pop_front();
        report("value", want.value, result.value);
        report("final_res", want.final_res, result.final_res);
        report("status", want.status, result.status);
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall = 0;
      else stall++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void queue_load(input logic [ELEM_W-1:0] e, input bit last_word);
    lvn_in_t w;
    w.command = CMD_LOAD;
    w.element = e;
    w.last    = last_word;
    pending_words.push_back(w);
    queued_words++;
  endfunction

  function automatic void queue_drain();
    lvn_in_t w;
    w.command = CMD_DRAIN;
    w.element = 16'($urandom_range(0, 65535));
    w.last    = 1'($urandom_range(0, 1));
    pending_words.push_back(w);
    queued_words++;
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      1: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One random sequence: mostly complete vectors drained in full or in part.
  function automatic void queue_random_seq();
    int n;
    int k;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) queue_load(pick_element(), i == n - 1);
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n + $urandom_range(0, 2);
      for (int i = 0; i < k; i++) queue_drain();
    end else if (kind == 7) begin
      // open vector with drains in between: each drain must come back empty
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        queue_load(pick_element(), 1'b0);
        if ($urandom_range(0, 1) == 1) queue_drain();
      end
    end else if (kind == 8) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) queue_drain();
    end else begin
      queue_load($urandom_range(0, 1) ? 16'h0000 : pick_element(), 1'b1);
      queue_drain();
      queue_drain();
    end
  endfunction

  task automatic settle();
    do @(posedge clk);
    while (pending_words.size() != 0 || have_word || results_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [SUM_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    threshold = v;
    threshold_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [SUM_W-1:0] t;
    sq_sum    = '0;
    n_loaded  = 0;
    drain_pos = 0;
    norm      = '0;
    vec_done  = 1'b0;
    divide_en = 1'b0;
    threshold = '0;
    gaps_on   = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_threshold('0);
    // drain before any vector, then field extremes through the divider
    queue_drain();
    queue_load(16'h7fff, 1'b0);
    queue_load(16'h8000, 1'b0);
    queue_load(16'h0000, 1'b0);
    queue_load(16'hffff, 1'b0);
    queue_load(16'h0001, 1'b1);
    repeat (6) queue_drain();
    // zero sum does not exceed a zero threshold: pass through
    queue_load(16'h0000, 1'b1);
    queue_drain();
    queue_drain();
    // single element divides to exactly one
    queue_load(16'h1000, 1'b1);
    queue_drain();
    // drain into an open vector, then finish it
    queue_load(16'd100, 1'b0);
    queue_drain();
    queue_load(16'd200, 1'b1);
    queue_drain();
    queue_drain();
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: t = SUM_W'(64'd1 << 40);
        1: t = SUM_W'($urandom_range(0, 32'h0100_0000));
        2: t = SUM_W'($urandom_range(0, 32'h7fff_ffff)) << $urandom_range(0, 9);
        3: t = SUM_W'({$urandom, $urandom});
        4: t = '0;
        default: t = SUM_W'($urandom_range(0, 32'h4000_0000));
      endcase
      write_threshold(t);
      // last stretch runs with no sender gaps
      if (p == 5) gaps_on = 1'b0;
      queued_words = 0;
      while (queued_words < PHASE_WORDS) queue_random_seq();
      settle();
    end

    $display("Covered %0d loads and %0d drains, %0d results checked, %0d threshold writes.",
             words_loaded, words_drained, results_checked, threshold_writes);
    $display("Included field extremes, zero sums, drains into open vectors and sender gaps.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lvn_pkg.sv
hdl/lvn_square.sv
hdl/lvn_isqrt.sv
hdl/lvn_div.sv
hdl/l2_vector_normalizer.sv
verif/tb_top.sv
